FILE: design/iface_packet_error_rate_monitor_unit_defines.svh
// Assertion macros for the packet error rate monitor.
`ifndef IFACE_PACKET_ERROR_RATE_MONITOR_UNIT_DEFINES_SVH
`define IFACE_PACKET_ERROR_RATE_MONITOR_UNIT_DEFINES_SVH

`define PERM_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

`define PERM_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

FILE: design/perm_pkg.sv
`default_nettype none
package perm_pkg;
  localparam int NumIfaces = 32;
  localparam int IfaceBits = 5;
  localparam int CountBits = 32;
  localparam int QueueDepth = 4;
  localparam int QueuePtrBits = 2;

  localparam logic [1:0] ReqPacket = 2'd0;
  localparam logic [1:0] ReqTick   = 2'd1;
  localparam logic [1:0] ReqClear  = 2'd2;

  localparam logic [2:0] AddrThreshold = 3'd0;
  localparam logic [2:0] AddrMaxPeriods = 3'd1;
  localparam logic [2:0] AddrCoeff = 3'd2;
  localparam logic [2:0] AddrFilterMask = 3'd3;
  localparam logic [2:0] AddrReasonSet = 3'd4;
  localparam logic [2:0] AddrIfaceMask = 3'd5;

  typedef enum logic [1:0] {
    OpPacket = 2'd0,
    OpPacketErr = 2'd1,
    OpTick = 2'd2,
    OpClear = 2'd3
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [IfaceBits-1:0] iface;
    logic [3:0]           modem;
    logic [7:0]           session;
  } cmd_t;

  typedef struct packed {
    logic [31:0] error_threshold;
    logic [15:0] max_periods;
    logic [7:0]  ratio_coefficient;
  } cfg_t;
endpackage
`default_nettype wire

FILE: design/perm_front.sv
`default_nettype none
module perm_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [4:0]         iface_i,
  input  wire logic               is_ip_i,
  input  wire logic [31:0]        filter_result_i,
  input  wire logic [5:0]         reason_code_i,
  input  wire logic [3:0]         modem_i,
  input  wire logic [7:0]         session_i,
  input  wire logic [31:0]        filter_error_mask_i,
  input  wire logic [63:0]        error_reason_set_i,
  input  wire logic [31:0]        monitored_iface_mask_i,
  output logic                    q_valid_o,
  input  wire logic               q_ready_i,
  output perm_pkg::cmd_t          q_cmd_o
);
  perm_pkg::cmd_t mem_q [perm_pkg::QueueDepth];
  logic [perm_pkg::QueuePtrBits-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [perm_pkg::QueuePtrBits:0] cnt_q, cnt_d;
  perm_pkg::cmd_t cmd;
  logic keep, push, pop;

  always_comb begin
    cmd.iface = iface_i;
    cmd.modem = modem_i;
    cmd.session = session_i;
    cmd.op = perm_pkg::OpPacket;
    keep = 1'b0;
    case (req_type_i)
      perm_pkg::ReqPacket: begin
        keep = monitored_iface_mask_i[iface_i] && is_ip_i;
        if ((filter_result_i & filter_error_mask_i) != 32'd0 ||
            error_reason_set_i[reason_code_i]) begin
          cmd.op = perm_pkg::OpPacketErr;
        end
      end
      perm_pkg::ReqTick: begin
        keep = 1'b1;
        cmd.op = perm_pkg::OpTick;
      end
      perm_pkg::ReqClear: begin
        keep = 1'b1;
        cmd.op = perm_pkg::OpClear;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o = cnt_q != (perm_pkg::QueuePtrBits+1)'(perm_pkg::QueueDepth);
  assign push = in_valid_i && in_ready_o && keep;
  assign q_valid_o = cnt_q != '0;
  assign pop = q_valid_o && q_ready_i;
  assign q_cmd_o = mem_q[rd_q];
  assign wr_d = push ? wr_q + 1'b1 : wr_q;
  assign rd_d = pop ? rd_q + 1'b1 : rd_q;
  assign cnt_d = cnt_q + {{perm_pkg::QueuePtrBits{1'b0}}, push}
               - {{perm_pkg::QueuePtrBits{1'b0}}, pop};

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end
endmodule
`default_nettype wire

FILE: design/perm_back.sv
`default_nettype none
module perm_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_valid_i,
  output logic              q_ready_o,
  input  perm_pkg::cmd_t    q_cmd_i,
  input  perm_pkg::cfg_t    cfg_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [4:0]        out_iface_o,
  output logic              out_kind_o,
  output logic [3:0]        out_modem_o,
  output logic [7:0]        out_session_o,
  output logic              out_last_o
);
  localparam int CB = perm_pkg::CountBits;
  localparam int NI = perm_pkg::NumIfaces;
  localparam int IB = perm_pkg::IfaceBits;
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StEval = 2'd1;
  localparam logic [1:0] StMul = 2'd2;
  localparam logic [1:0] StApply = 2'd3;

  logic [15:0]   pidx_q [NI];
  logic [CB-1:0] perr_q [NI];
  logic [CB-1:0] ppkt_q [NI];
  logic [CB-1:0] tot_q  [NI];
  logic [3:0]    mod_q  [NI];
  logic [7:0]    ses_q  [NI];
  logic [NI-1:0] act_q;

  logic [1:0] st_q, st_d;
  logic [IB:0] idx_q, idx_d;
  logic [CB+7:0] prod_q;
  logic pend_q;
  logic [IB-1:0] pend_i_q;

  logic ov_q, ol_q, ok_q;
  logic [4:0] oi_q;
  logic [3:0] om_q;
  logic [7:0] os_q;

  logic out_free;
  logic [IB-1:0] ci, si;
  logic [NI-1:0] later;
  logic more;
  logic [CB-1:0] cmax;

  assign cmax = '1;
  assign out_free = !ov_q || out_ready_i;
  assign ci = q_cmd_i.iface;
  assign si = idx_q[IB-1:0];
  assign q_ready_o = (st_q == StIdle) && out_free && !pend_q;

  always_comb begin
    later = '0;
    for (int k = 0; k < NI; k++) later[k] = act_q[k] && (k > int'(idx_q));
    more = later != '0;
  end

  always_comb begin
    st_d = st_q;
    idx_d = idx_q;
    case (st_q)
      StIdle: if (q_valid_i && q_ready_o && q_cmd_i.op == perm_pkg::OpTick) begin
        st_d = StEval;
        idx_d = '0;
      end
      StEval: begin
        if (idx_q == (IB+1)'(NI)) begin
          if (!pend_q || out_free) st_d = StIdle;
        end else if (!act_q[si]) idx_d = idx_q + 1'b1;
        else if (tot_q[si] >= cfg_i.error_threshold) begin
          if (!pend_q || out_free) st_d = StApply;
        end else st_d = StMul;
      end
      StMul: st_d = StApply;
      StApply: if (!pend_q || out_free) begin
        st_d = StEval;
        idx_d = idx_q + 1'b1;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StEval) prod_q <= perr_q[si] * cfg_i.ratio_coefficient;
  end

  logic rep;
  logic [15:0] ninc;
  always_comb begin
    ninc = (pidx_q[si] == 16'hffff) ? pidx_q[si] : pidx_q[si] + 16'd1;
    rep = (tot_q[si] >= cfg_i.error_threshold) || (!({8'd0, ppkt_q[si]} >= prod_q)
          && ninc >= cfg_i.max_periods);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      idx_q <= '0;
      act_q <= '0;
      pend_q <= 1'b0;
      pend_i_q <= '0;
      ov_q <= 1'b0;
      ol_q <= 1'b0;
      ok_q <= 1'b0;
      oi_q <= '0;
      om_q <= '0;
      os_q <= '0;
      for (int k = 0; k < NI; k++) begin
        pidx_q[k] <= '0;
        perr_q[k] <= '0;
        ppkt_q[k] <= '0;
        tot_q[k] <= '0;
        mod_q[k] <= '0;
        ses_q[k] <= '0;
      end
    end else begin
      st_q <= st_d;
      idx_q <= idx_d;
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      // a held report goes out when the next one (or the sweep end) is known
      if (pend_q && out_free && ((st_q == StApply && rep) ||
          (st_q == StEval && (idx_q == (IB+1)'(NI) || !more && !act_q[si])))) begin
        ov_q <= 1'b1;
        ok_q <= 1'b1;
        oi_q <= 5'(pend_i_q);
        om_q <= mod_q[pend_i_q];
        os_q <= ses_q[pend_i_q];
        ol_q <= (st_q != StApply);
        pend_q <= 1'b0;
      end
      if (st_q == StIdle && q_valid_i && q_ready_o) begin
        case (q_cmd_i.op)
          perm_pkg::OpPacket: if (ppkt_q[ci] != cmax) ppkt_q[ci] <= ppkt_q[ci] + 1'b1;
          perm_pkg::OpPacketErr: begin
            if (tot_q[ci] != cmax) tot_q[ci] <= tot_q[ci] + 1'b1;
            if (perr_q[ci] != cmax) perr_q[ci] <= perr_q[ci] + 1'b1;
            if (pidx_q[ci] == 16'd0 && perr_q[ci] == '0) begin
              mod_q[ci] <= q_cmd_i.modem;
              ses_q[ci] <= q_cmd_i.session;
              ppkt_q[ci] <= CB'(1);
              act_q[ci] <= 1'b1;
              ov_q <= 1'b1;
              ok_q <= 1'b0;
              ol_q <= 1'b1;
              oi_q <= 5'(ci);
              om_q <= q_cmd_i.modem;
              os_q <= q_cmd_i.session;
            end else if (ppkt_q[ci] != cmax) ppkt_q[ci] <= ppkt_q[ci] + 1'b1;
          end
          perm_pkg::OpClear: begin
            pidx_q[ci] <= '0;
            perr_q[ci] <= '0;
            ppkt_q[ci] <= '0;
            tot_q[ci] <= '0;
            act_q[ci] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (st_q == StApply && (!pend_q || out_free)) begin
        perr_q[si] <= '0;
        ppkt_q[si] <= '0;
        if (rep) begin
          pidx_q[si] <= '0;
          tot_q[si] <= '0;
          act_q[si] <= 1'b0;
          pend_q <= 1'b1;
          pend_i_q <= si;
        end else if ({8'd0, ppkt_q[si]} >= prod_q && tot_q[si] < cfg_i.error_threshold) begin
          pidx_q[si] <= '0;
          act_q[si] <= 1'b0;
        end else begin
          pidx_q[si] <= ninc;
        end
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_iface_o = oi_q;
  assign out_kind_o = ok_q;
  assign out_modem_o = om_q;
  assign out_session_o = os_q;
  assign out_last_o = ol_q;
endmodule
`default_nettype wire

FILE: design/iface_packet_error_rate_monitor_unit.sv
// Packet/clear beats pass through a 4-entry queue; a start report goes from the queue entry to the output register.
// Tick: sweep of the 32 interfaces in the back end; an idle interface is skipped in eval, an
// active one steps through eval (compare, ratio multiply), mul and apply (update), skipping mul
// when over threshold; output stalls hold the sweep; input stalls once queue fills.
// Reset (rst_ni low, async): all counters, active bits and ids zero; registers to defaults.
`default_nettype none
module iface_packet_error_rate_monitor_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: iface[4:0], is_ip_packet[5], filter_result[37:6], reason_code[43:38],
  // modem_number[47:44], session_number[55:48]
  input  wire logic [55:0] s_axis_tdata_i,
  // tuser: req_type[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata: report_iface[4:0], report_modem[8:5], report_session[16:9], zero fill
  output logic [23:0]      m_axis_tdata_o,
  // tuser: report_kind
  output logic             m_axis_tuser_o,
  output logic             m_axis_tlast_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  logic [31:0] thr_q, fmask_q, imask_q;
  logic [15:0] maxp_q;
  logic [7:0]  coef_q;
  logic [63:0] rset_q;
  logic [2:0]  ra;
  perm_pkg::cmd_t qcmd;
  perm_pkg::cfg_t cfg;
  logic qv, qr;
  logic [4:0] oi;
  logic [3:0] om;
  logic [7:0] os;

  assign pready = 1'b1;
  assign ra = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 32'd10;
      maxp_q <= 16'd3;
      coef_q <= 8'd10;
      fmask_q <= '0;
      rset_q <= '0;
      imask_q <= '1;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      case (ra)
        perm_pkg::AddrThreshold: thr_q <= pwdata[31:0];
        perm_pkg::AddrMaxPeriods: maxp_q <= pwdata[15:0];
        perm_pkg::AddrCoeff: coef_q <= pwdata[7:0];
        perm_pkg::AddrFilterMask: fmask_q <= pwdata[31:0];
        perm_pkg::AddrReasonSet: rset_q <= pwdata;
        perm_pkg::AddrIfaceMask: imask_q <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ra)
      perm_pkg::AddrThreshold: prdata = {32'd0, thr_q};
      perm_pkg::AddrMaxPeriods: prdata = {48'd0, maxp_q};
      perm_pkg::AddrCoeff: prdata = {56'd0, coef_q};
      perm_pkg::AddrFilterMask: prdata = {32'd0, fmask_q};
      perm_pkg::AddrReasonSet: prdata = rset_q;
      perm_pkg::AddrIfaceMask: prdata = {32'd0, imask_q};
      default: prdata = '0;
    endcase
  end

  assign cfg.error_threshold = thr_q;
  assign cfg.max_periods = maxp_q;
  assign cfg.ratio_coefficient = coef_q;

  perm_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .req_type_i(s_axis_tuser_i), .iface_i(s_axis_tdata_i[4:0]),
    .is_ip_i(s_axis_tdata_i[5]), .filter_result_i(s_axis_tdata_i[37:6]),
    .reason_code_i(s_axis_tdata_i[43:38]), .modem_i(s_axis_tdata_i[47:44]),
    .session_i(s_axis_tdata_i[55:48]),
    .filter_error_mask_i(fmask_q), .error_reason_set_i(rset_q),
    .monitored_iface_mask_i(imask_q),
    .q_valid_o(qv), .q_ready_i(qr), .q_cmd_o(qcmd)
  );

  perm_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(qv), .q_ready_o(qr), .q_cmd_i(qcmd), .cfg_i(cfg),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .out_iface_o(oi), .out_kind_o(m_axis_tuser_o), .out_modem_o(om),
    .out_session_o(os), .out_last_o(m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {7'd0, os, om, oi};
endmodule
`default_nettype wire

FILE: design/perm_checker.sv
`default_nettype none
`include "iface_packet_error_rate_monitor_unit_defines.svh"
module perm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);
  `PERM_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))
  `PERM_ASSERT_IMP(a_start_last, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tlast_o)
  `PERM_ASSERT_IMP(a_pad, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o[23:17] == 7'd0)
endmodule

bind iface_packet_error_rate_monitor_unit perm_checker u_perm_checker (
  .clk_i, .rst_ni, .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o,
  .m_axis_tuser_o, .m_axis_tlast_o
);
`default_nettype wire

FILE: tb/perm_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module perm_scoreboard (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [55:0] s_axis_tdata_i,
  input  wire logic [1:0]  s_axis_tuser_i,
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [23:0] m_axis_tdata_i,
  input  wire logic        m_axis_tuser_i,
  input  wire logic        m_axis_tlast_i,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  input  wire logic        pready,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [4:0] iface;
    logic       kind;
    logic [3:0] modem;
    logic [7:0] session;
    logic       last;
  } report_t;

  localparam logic KindStart = 1'b0;
  localparam logic KindFail  = 1'b1;

  logic [31:0] thr_q, fmask_q, imask_q;
  logic [15:0] maxp_q;
  logic [7:0]  coeff_q;
  logic [63:0] rset_q;

  logic [15:0] per_idx [perm_pkg::NumIfaces];
  logic [31:0] per_err [perm_pkg::NumIfaces];
  logic [31:0] per_pkt [perm_pkg::NumIfaces];
  logic [31:0] tot_err [perm_pkg::NumIfaces];
  logic [3:0]  id_modem [perm_pkg::NumIfaces];
  logic [7:0]  id_session [perm_pkg::NumIfaces];
  logic [31:0] active_q;

  report_t expected_reports[$];
  int fails;

  function automatic logic [31:0] sat32(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  task automatic zero_iface(int i);
    per_idx[i] = '0;
    per_err[i] = '0;
    per_pkt[i] = '0;
    tot_err[i] = '0;
    active_q[i] = 1'b0;
  endtask

  task automatic add_report(int i, logic kind, bit last);
    report_t r;
    r.iface = i[4:0];
    r.kind = kind;
    r.modem = id_modem[i];
    r.session = id_session[i];
    r.last = last;
    expected_reports.push_back(r);
  endtask

  task automatic predict_beat(logic [1:0] req, logic [55:0] d);
    logic [4:0] ifc;
    logic [31:0] fres;
    logic [5:0] reason;
    bit err, rep;
    int n;
    report_t r;
    ifc = d[4:0];
    fres = d[37:6];
    reason = d[43:38];
    n = 0;
    if (req == perm_pkg::ReqPacket) begin
      if (imask_q[ifc] && d[5]) begin
        per_pkt[ifc] = sat32(per_pkt[ifc]);
        err = ((fres & fmask_q) != 0) || rset_q[reason];
        if (err) begin
          tot_err[ifc] = sat32(tot_err[ifc]);
          per_err[ifc] = sat32(per_err[ifc]);
          if (per_idx[ifc] == 0 && per_err[ifc] == 32'd1) begin
            id_modem[ifc] = d[47:44];
            id_session[ifc] = d[55:48];
            per_pkt[ifc] = 32'd1;
            active_q[ifc] = 1'b1;
            add_report(ifc, KindStart, 1'b1);
          end
        end
      end
    end else if (req == perm_pkg::ReqTick) begin
      for (int i = 0; i < perm_pkg::NumIfaces; i++) begin
        if (active_q[i]) begin
          rep = 1'b0;
          if (tot_err[i] >= thr_q) begin
            rep = 1'b1;
          end else if (64'(per_pkt[i]) >= 64'(per_err[i]) * 64'(coeff_q)) begin
            per_idx[i] = '0;
            per_err[i] = '0;
            per_pkt[i] = '0;
            active_q[i] = 1'b0;
          end else begin
            if (per_idx[i] != 16'hFFFF) per_idx[i] = per_idx[i] + 16'd1;
            per_err[i] = '0;
            per_pkt[i] = '0;
            if (per_idx[i] >= maxp_q) rep = 1'b1;
          end
          if (rep) begin
            add_report(i, KindFail, 1'b0);
            n++;
            zero_iface(i);
          end
        end
      end
      if (n > 0) begin
        r = expected_reports.pop_back();
        r.last = 1'b1;
        expected_reports.push_back(r);
      end
    end else if (req == perm_pkg::ReqClear) begin
      zero_iface(ifc);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    report_t want, got;
    if (!rst_ni) begin
      thr_q = 32'd10;
      maxp_q = 16'd3;
      coeff_q = 8'd10;
      fmask_q = '0;
      rset_q = '0;
      imask_q = 32'hFFFF_FFFF;
      for (int i = 0; i < perm_pkg::NumIfaces; i++) begin
        zero_iface(i);
        id_modem[i] = '0;
        id_session[i] = '0;
      end
      active_q = '0;
      expected_reports.delete();
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          perm_pkg::AddrThreshold:  thr_q = pwdata[31:0];
          perm_pkg::AddrMaxPeriods: maxp_q = pwdata[15:0];
          perm_pkg::AddrCoeff:      coeff_q = pwdata[7:0];
          perm_pkg::AddrFilterMask: fmask_q = pwdata[31:0];
          perm_pkg::AddrReasonSet:  rset_q = pwdata;
          perm_pkg::AddrIfaceMask:  imask_q = pwdata[31:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.iface = m_axis_tdata_i[4:0];
        got.modem = m_axis_tdata_i[8:5];
        got.session = m_axis_tdata_i[16:9];
        got.kind = m_axis_tuser_i;
        got.last = m_axis_tlast_i;
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report beat %p", $time, got);
          fails++;
        end else begin
          want = expected_reports.pop_front();
          if (got.iface != want.iface)
            $display("%0t: iface exp %0d got %0d", $time, want.iface, got.iface);
          if (got.kind != want.kind)
            $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
          if (got.modem != want.modem)
            $display("%0t: modem exp %0d got %0d", $time, want.modem, got.modem);
          if (got.session != want.session)
            $display("%0t: session exp %0d got %0d", $time, want.session, got.session);
          if (got.last != want.last)
            $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
          if (got != want) fails++;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) predict_beat(s_axis_tuser_i, s_axis_tdata_i);
    end
    fail_count_o <= fails;
    pending_o <= expected_reports.size();
  end

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam logic [1:0] ReqUnused = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [55:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  wire logic        s_ready, m_valid, m_user, m_last, pready;
  wire logic [23:0] m_data;
  wire logic [63:0] prdata;
  int  fail_count, pending;
  bit  calm = 1'b0;
  logic [4:0] hot [4];

  iface_packet_error_rate_monitor_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  perm_scoreboard chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_i(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_i(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_i(m_data), .m_axis_tuser_i(m_user), .m_axis_tlast_i(m_last),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial forever #10 clk_i = ~clk_i;

  always @(posedge clk_i) m_ready <= calm || ($urandom_range(99) >= 18);

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send(logic [1:0] req, logic [4:0] ifc, logic ip, logic [31:0] fres,
                      logic [5:0] reason, logic [3:0] modem, logic [7:0] sess);
    bit rdy;
    while (!calm && $urandom_range(99) < 18) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user <= req;
    s_data <= {sess, modem, reason, fres, ip, ifc};
    do begin
      @(negedge clk_i);
      rdy = s_ready;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [63:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic rand_config();
    reg_write(perm_pkg::AddrThreshold, 64'($urandom_range(9)));
    reg_write(perm_pkg::AddrMaxPeriods, 64'($urandom_range(4)));
    reg_write(perm_pkg::AddrCoeff, 64'($urandom_range(6, 1)));
    reg_write(perm_pkg::AddrFilterMask, 64'(32'h1 << $urandom_range(31)));
    reg_write(perm_pkg::AddrReasonSet, {$urandom, $urandom});
    reg_write(perm_pkg::AddrIfaceMask, {$urandom, $urandom} | 64'h0000_0000_8421_8421);
    for (int k = 0; k < 4; k++) hot[k] = ($urandom_range(3) == 0) ? 5'(k) : 5'($urandom);
  endtask

  task automatic rand_item();
    int sel;
    logic [31:0] fres;
    sel = $urandom_range(99);
    fres = ($urandom_range(2) == 0) ? $urandom : 32'h0;
    if (sel < 8)
      send(perm_pkg::ReqTick, 5'($urandom), 1'($urandom), $urandom, 6'($urandom),
           4'($urandom), 8'($urandom));
    else if (sel < 11)
      send(perm_pkg::ReqClear, hot[$urandom_range(3)], 1'($urandom), $urandom,
           6'($urandom), 4'($urandom), 8'($urandom));
    else if (sel < 13)
      send(ReqUnused, 5'($urandom), 1'($urandom), $urandom, 6'($urandom),
           4'($urandom), 8'($urandom));
    else if (sel < 16)
      send(perm_pkg::ReqPacket, 5'($urandom), 1'($urandom), $urandom, 6'($urandom),
           4'($urandom), 8'($urandom));
    else
      send(perm_pkg::ReqPacket, hot[$urandom_range(3)], $urandom_range(9) != 0, fres,
           6'($urandom), 4'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(perm_pkg::ReqPacket, 5'd3, 1'b1, 32'hFFFF_FFFF, 6'd63, 4'hF, 8'hFF);
    send(perm_pkg::ReqTick, 5'd0, 1'b0, 32'h0, 6'd0, 4'h0, 8'h0);
    drain();
    reg_write(perm_pkg::AddrThreshold, 64'd4);
    reg_write(perm_pkg::AddrMaxPeriods, 64'd2);
    reg_write(perm_pkg::AddrCoeff, 64'd3);
    reg_write(perm_pkg::AddrFilterMask, 64'h0000_00F0);
    reg_write(perm_pkg::AddrReasonSet, 64'h8000_0000_0000_0001);
    reg_write(perm_pkg::AddrIfaceMask, 64'hFFFF_FFFE);
    send(perm_pkg::ReqPacket, 5'd0, 1'b1, 32'hFFFF_FFFF, 6'd63, 4'h1, 8'h01);
    send(perm_pkg::ReqPacket, 5'd1, 1'b0, 32'hFFFF_FFFF, 6'd0, 4'h2, 8'h02);
    send(perm_pkg::ReqPacket, 5'd1, 1'b1, 32'h0000_0010, 6'd5, 4'hA, 8'h5A);
    send(perm_pkg::ReqPacket, 5'd31, 1'b1, 32'h0, 6'd63, 4'hF, 8'hFF);
    send(perm_pkg::ReqPacket, 5'd2, 1'b1, 32'hFFFF_FF0F, 6'd0, 4'h0, 8'h00);
    send(perm_pkg::ReqPacket, 5'd2, 1'b1, 32'h0, 6'd1, 4'h3, 8'h33);
    send(perm_pkg::ReqClear, 5'd2, 1'b0, 32'h0, 6'd0, 4'h0, 8'h0);
    send(ReqUnused, 5'd1, 1'b1, 32'hFFFF_FFFF, 6'd63, 4'hF, 8'hFF);
    send(perm_pkg::ReqPacket, 5'd31, 1'b1, 32'h0, 6'd2, 4'h0, 8'h0);
    send(perm_pkg::ReqPacket, 5'd31, 1'b1, 32'h0, 6'd2, 4'h0, 8'h0);
    send(perm_pkg::ReqPacket, 5'd31, 1'b1, 32'h0, 6'd2, 4'h0, 8'h0);
    send(perm_pkg::ReqTick, 5'd0, 1'b0, 32'h0, 6'd0, 4'h0, 8'h0);
    send(perm_pkg::ReqPacket, 5'd1, 1'b1, 32'h80, 6'd0, 4'h5, 8'h55);
    send(perm_pkg::ReqTick, 5'd0, 1'b0, 32'h0, 6'd0, 4'h0, 8'h0);
    send(perm_pkg::ReqTick, 5'd0, 1'b0, 32'h0, 6'd0, 4'h0, 8'h0);
    drain();
    // degenerate settings: everything reports at once, zero coefficient
    reg_write(perm_pkg::AddrThreshold, 64'd0);
    reg_write(perm_pkg::AddrMaxPeriods, 64'd0);
    reg_write(perm_pkg::AddrCoeff, 64'd0);
    reg_write(perm_pkg::AddrIfaceMask, 64'hFFFF_FFFF);
    for (int k = 0; k < 32; k++)
      send(perm_pkg::ReqPacket, 5'(k), 1'b1, 32'hFFFF_FFFF, 6'd0, 4'(k), 8'(~k));
    send(perm_pkg::ReqTick, 5'd0, 1'b0, 32'h0, 6'd0, 4'h0, 8'h0);
    drain();
    reg_write(perm_pkg::AddrThreshold, 64'hFFFF_FFFF);
    reg_write(perm_pkg::AddrMaxPeriods, 64'hFFFF);
    reg_write(perm_pkg::AddrCoeff, 64'd255);
    reg_write(perm_pkg::AddrReasonSet, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int k = 0; k < 6; k++) begin
      send(perm_pkg::ReqPacket, 5'd7, 1'b1, 32'h0, 6'(k), 4'h7, 8'h77);
      send(perm_pkg::ReqTick, 5'd0, 1'b0, 32'h0, 6'd0, 4'h0, 8'h0);
    end
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      rand_config();
      calm = (ph == 3);
      for (int j = 0; j < 35; j++) begin
        rand_item();
        if (ph == 2 && j == 20) drain();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
+incdir+design
design/perm_pkg.sv
design/perm_front.sv
design/perm_back.sv
design/iface_packet_error_rate_monitor_unit.sv
design/perm_checker.sv
tb/perm_checker.sv
tb/tb.sv
